>>> hw/rtl/lps_pkg.sv
// shared types, constants and codes for the five channel led pulse serializer
package lps_pkg;

  localparam int MAX_PIXELS = 256;
  localparam int PIX_AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CMP_W = ((PIX_AW + 1 > 9) ? PIX_AW + 1 : 9) + 1;
  localparam int WORD_W = 40;
  localparam int TICK_W = 16;

  localparam logic [8:0] RST_PIXEL_COUNT = 9'd1;
  localparam logic [7:0] RST_T0_HIGH = 8'd3;
  localparam logic [7:0] RST_T0_LOW = 8'd10;
  localparam logic [7:0] RST_T1_HIGH = 8'd7;
  localparam logic [7:0] RST_T1_LOW = 8'd6;
  localparam logic [15:0] RST_LATCH_LOW = 16'd3000;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_SEND  = 2'd1,
    OP_TICK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_BUSY  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_PIXEL_COUNT = 3'd0,
    REG_T0_HIGH     = 3'd1,
    REG_T0_LOW      = 3'd2,
    REG_T1_HIGH     = 3'd3,
    REG_T1_LOW      = 3'd4,
    REG_LATCH_LOW   = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HIGH,
    S_LOW,
    S_LATCH,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic    tick_inc;
    logic    tick_clr;
    logic    shift;
    logic    bit_inc;
    logic    bit_clr;
    logic    byte_inc;
    logic    byte_clr;
    logic    pix_inc;
    logic    pix_clr;
    logic    rd_en;
    logic    rd_first;
    logic    rd_clear;
    logic    load_word;
    logic    clr_set;
    logic    clr_val;
    logic    clr_drop;
    logic    wr_en;
    logic    out_load;
    logic    out_level;
    logic    out_busy;
    status_t out_status;
  } lps_cmd_t;

  typedef struct packed {
    logic high_done;
    logic low_done;
    logic latch_done;
    logic bit_last;
    logic byte_last;
    logic pix_last;
    logic idx_bad;
    logic clearing;
    logic out_valid;
  } lps_stat_t;

endpackage

>>> hw/rtl/five_channel_led_pulse_serializer_top.sv
// top level of the five channel led pulse serializer
//
// requests enter on the in_ channel (in_valid / in_stall) and each one gives
// exactly one result on the out_ channel (out_valid / out_stall), in the cycle
// after it is taken. a set request writes one pixel of five bytes into the
// store; a send or clear request starts a frame; a tick request advances the
// line by one period and reports its level. requests other than ticks are
// answered with a busy status while a frame or latch period runs.
// ticks can be taken at one per cycle while in_stall is low. the
// pixel store has a registered read port, so a send or clear request and the
// tick that ends each pixel are followed by the S_LOAD state, with in_stall
// high, while the next pixel word is fetched.
// configuration is written on the cfg_ channel (cfg_valid / cfg_ready, always
// ready); the user must write it only while no frame runs (not enforced here).
// reset clears the pixel store (per-entry valid bits, at once), the frame
// state and the timing registers to their defaults. a stalled result holds
// in the output register, and in_stall stays high until it is taken.
module five_channel_led_pulse_serializer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_pixel_index,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_white_one,
  input  logic [7:0]  in_white_two,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_line_level,
  output logic        out_busy_res,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import lps_pkg::*;

  lps_cmd_t  cmd;
  lps_stat_t stat;

  assign cfg_ready = 1'b1;

  lps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .out_stall (out_stall),
    .stat      (stat),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  lps_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_pixel_index (in_pixel_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_white_one   (in_white_one),
    .in_white_two   (in_white_two),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_line_level (out_line_level),
    .out_busy_res   (out_busy_res),
    .out_status     (out_status)
  );

  // every taken request shows a result in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("request taken without a result");

  // a high line only occurs inside a frame
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_level |-> out_busy_res && out_status == STS_OK)
    else $error("line high outside a frame");

  // a busy rejection always reports a running frame
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STS_BUSY |-> out_busy_res)
    else $error("busy status without a running frame");

  // a range error only comes from an idle block
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STS_RANGE |-> !out_busy_res && !out_line_level)
    else $error("range error while busy");

endmodule

>>> hw/rtl/lps_dp.sv
// datapath: config registers, pixel store, shift word, counters, result register
module lps_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  lps_pkg::lps_cmd_t  cmd,
  output lps_pkg::lps_stat_t stat,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic [7:0]         in_pixel_index,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  input  logic [7:0]         in_white_one,
  input  logic [7:0]         in_white_two,
  input  logic               out_stall,
  output logic               out_valid,
  output logic               out_line_level,
  output logic               out_busy_res,
  output logic [1:0]         out_status
);
  import lps_pkg::*;

  logic [8:0]  pixel_count_r;
  logic [7:0]  t0_high_r, t0_low_r, t1_high_r, t1_low_r;
  logic [15:0] latch_low_r;

  logic [WORD_W-1:0] mem [MAX_PIXELS];
  logic [MAX_PIXELS-1:0] vld_r;
  logic [WORD_W-1:0] rd_data_r;
  logic              rd_vld_r;

  logic [WORD_W-1:0] shift_r;
  logic [TICK_W-1:0] tick_r;
  logic [2:0]        bit_r;
  logic [2:0]        byte_r;
  logic [PIX_AW-1:0] pix_r;
  logic              clearing_r;

  logic              out_valid_r;
  logic              out_level_r;
  logic              out_busy_r;
  logic [1:0]        out_status_r;

  logic [CMP_W-1:0]  pc_ext, live_cnt, idx_ext, pix_next_ext;
  logic [PIX_AW-1:0] waddr, raddr;
  logic [WORD_W-1:0] wdata;
  logic              cur_bit;
  logic [7:0]        dur_hi_raw, dur_lo_raw, dur_hi, dur_lo;
  logic [15:0]       dur_latch;
  logic [TICK_W:0]   tick_inc_v;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_count_r <= RST_PIXEL_COUNT;
      t0_high_r     <= RST_T0_HIGH;
      t0_low_r      <= RST_T0_LOW;
      t1_high_r     <= RST_T1_HIGH;
      t1_low_r      <= RST_T1_LOW;
      latch_low_r   <= RST_LATCH_LOW;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_PIXEL_COUNT: pixel_count_r <= cfg_wdata[8:0];
        REG_T0_HIGH:     t0_high_r     <= cfg_wdata[7:0];
        REG_T0_LOW:      t0_low_r      <= cfg_wdata[7:0];
        REG_T1_HIGH:     t1_high_r     <= cfg_wdata[7:0];
        REG_T1_LOW:      t1_low_r      <= cfg_wdata[7:0];
        REG_LATCH_LOW:   latch_low_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective pixel count and index checks
  always_comb begin
    pc_ext = CMP_W'(pixel_count_r);
    if (pc_ext == '0) begin
      live_cnt = CMP_W'(1);
    end else if (pc_ext > CMP_W'(MAX_PIXELS)) begin
      live_cnt = CMP_W'(MAX_PIXELS);
    end else begin
      live_cnt = pc_ext;
    end
    idx_ext      = CMP_W'(in_pixel_index);
    pix_next_ext = CMP_W'(pix_r) + CMP_W'(1);
  end

  assign waddr = PIX_AW'(idx_ext);
  assign raddr = cmd.rd_first ? '0 : PIX_AW'(pix_next_ext);
  assign wdata = {in_green, in_red, in_blue, in_white_one, in_white_two};

  // pixel store, unwritten or cleared entries read as zero
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[raddr];
      rd_vld_r  <= vld_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.wr_en) begin
      vld_r[waddr] <= 1'b1;
    end else if (cmd.rd_en && cmd.rd_clear) begin
      vld_r[raddr] <= 1'b0;
    end
  end

  // bit timing
  always_comb begin
    cur_bit    = shift_r[WORD_W-1];
    dur_hi_raw = cur_bit ? t1_high_r : t0_high_r;
    dur_lo_raw = cur_bit ? t1_low_r : t0_low_r;
    dur_hi     = (dur_hi_raw == '0) ? 8'd1 : dur_hi_raw;
    dur_lo     = (dur_lo_raw == '0) ? 8'd1 : dur_lo_raw;
    dur_latch  = (latch_low_r == '0) ? 16'd1 : latch_low_r;
    tick_inc_v = {1'b0, tick_r} + 17'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r    <= '0;
      tick_r     <= '0;
      bit_r      <= '0;
      byte_r     <= '0;
      pix_r      <= '0;
      clearing_r <= 1'b0;
    end else begin
      if (cmd.load_word) begin
        shift_r <= rd_vld_r ? rd_data_r : '0;
      end else if (cmd.shift) begin
        shift_r <= {shift_r[WORD_W-2:0], 1'b0};
      end
      if (cmd.tick_clr) begin
        tick_r <= '0;
      end else if (cmd.tick_inc) begin
        tick_r <= tick_inc_v[TICK_W-1:0];
      end
      if (cmd.bit_clr) begin
        bit_r <= '0;
      end else if (cmd.bit_inc) begin
        bit_r <= bit_r + 3'd1;
      end
      if (cmd.byte_clr) begin
        byte_r <= '0;
      end else if (cmd.byte_inc) begin
        byte_r <= byte_r + 3'd1;
      end
      if (cmd.pix_clr) begin
        pix_r <= '0;
      end else if (cmd.pix_inc) begin
        pix_r <= PIX_AW'(pix_next_ext);
      end
      if (cmd.clr_set) begin
        clearing_r <= cmd.clr_val;
      end else if (cmd.clr_drop) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_load | (out_valid_r & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_level_r  <= cmd.out_level;
      out_busy_r   <= cmd.out_busy;
      out_status_r <= cmd.out_status;
    end
  end

  always_comb begin
    stat.high_done  = tick_inc_v >= 17'(dur_hi);
    stat.low_done   = tick_inc_v >= 17'(dur_lo);
    stat.latch_done = tick_inc_v >= 17'(dur_latch);
    stat.bit_last   = (bit_r == 3'd7);
    stat.byte_last  = (byte_r == 3'd4);
    stat.pix_last   = (pix_next_ext >= live_cnt);
    stat.idx_bad    = (idx_ext >= live_cnt) || (idx_ext >= CMP_W'(MAX_PIXELS));
    stat.clearing   = clearing_r;
    stat.out_valid  = out_valid_r;
  end

  assign out_valid      = out_valid_r;
  assign out_line_level = out_level_r;
  assign out_busy_res   = out_busy_r;
  assign out_status     = out_status_r;

endmodule

>>> hw/rtl/lps_ctrl.sv
// controller: frame phase state machine and request handling
module lps_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_op,
  input  logic               out_stall,
  input  lps_pkg::lps_stat_t stat,
  output logic               in_stall,
  output lps_pkg::lps_cmd_t  cmd
);
  import lps_pkg::*;

  state_t state_r, state_nxt;
  logic   in_fire;
  op_t    op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign op = op_t'(in_op);

  always_comb begin
    in_stall  = (state_r == S_LOAD) || (stat.out_valid && out_stall);
    in_fire   = in_valid && !in_stall;
    state_nxt = state_r;
    cmd       = '0;
    cmd.out_status = STS_OK;
    cmd.out_load   = in_fire;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (op)
            OP_SET: begin
              if (stat.idx_bad) begin
                cmd.out_status = STS_RANGE;
              end else begin
                cmd.wr_en = 1'b1;
              end
            end
            OP_SEND, OP_CLEAR: begin
              cmd.out_busy = 1'b1;
              cmd.rd_en    = 1'b1;
              cmd.rd_first = 1'b1;
              cmd.rd_clear = (op == OP_CLEAR);
              cmd.clr_set  = 1'b1;
              cmd.clr_val  = (op == OP_CLEAR);
              cmd.pix_clr  = 1'b1;
              cmd.byte_clr = 1'b1;
              cmd.bit_clr  = 1'b1;
              cmd.tick_clr = 1'b1;
              state_nxt    = S_LOAD;
            end
            default: ;
          endcase
        end
      end
      S_LOAD: begin
        cmd.load_word = 1'b1;
        state_nxt     = S_HIGH;
      end
      S_HIGH, S_LOW, S_LATCH: begin
        if (in_fire) begin
          cmd.out_busy = 1'b1;
          if (op != OP_TICK) begin
            cmd.out_status = STS_BUSY;
          end else begin
            case (state_r)
              S_HIGH: begin
                cmd.out_level = 1'b1;
                if (stat.high_done) begin
                  cmd.tick_clr = 1'b1;
                  state_nxt    = S_LOW;
                end else begin
                  cmd.tick_inc = 1'b1;
                end
              end
              S_LOW: begin
                if (stat.low_done) begin
                  cmd.shift    = 1'b1;
                  cmd.tick_clr = 1'b1;
                  state_nxt    = S_HIGH;
                  if (!stat.bit_last) begin
                    cmd.bit_inc = 1'b1;
                  end else begin
                    cmd.bit_clr = 1'b1;
                    if (!stat.byte_last) begin
                      cmd.byte_inc = 1'b1;
                    end else begin
                      cmd.byte_clr = 1'b1;
                      if (stat.pix_last) begin
                        state_nxt = S_LATCH;
                      end else begin
                        cmd.pix_inc  = 1'b1;
                        cmd.rd_en    = 1'b1;
                        cmd.rd_clear = stat.clearing;
                        state_nxt    = S_LOAD;
                      end
                    end
                  end
                end else begin
                  cmd.tick_inc = 1'b1;
                end
              end
              default: begin
                if (stat.latch_done) begin
                  cmd.tick_clr = 1'b1;
                  cmd.clr_drop = 1'b1;
                  state_nxt    = S_IDLE;
                end else begin
                  cmd.tick_inc = 1'b1;
                end
              end
            endcase
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
